/* sv/raot_pkg.sv */
// ----------------------------------------------------------------------------
// raot_pkg
// Shared types, constants and helpers for the RTC alarm time offset block.
// ----------------------------------------------------------------------------
package raot_pkg;

  // Stream widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  // Alarm weekday byte composition
  localparam logic [7:0] FULL_MATCH_MASK = 8'h70;
  localparam logic [7:0] KEEP_WDAY_MASK  = 8'hF8;

  // Delay split constants
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [6:0]  SEC_PER_MIN  = 7'd60;

  // Reciprocal multipliers: the estimate is low by at most one
  localparam logic [10:0] HOUR_RECIP = 11'd1165;  // floor(2^22 / 3600)
  localparam int          HOUR_SHIFT = 22;
  localparam logic [10:0] MIN_RECIP  = 11'd1092;  // floor(2^16 / 60)
  localparam int          MIN_SHIFT  = 16;

  // Default queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Decoded clock registers
  typedef struct packed {
    logic [6:0] sec;    // up to 85 with bad digits
    logic [6:0] min;
    logic [5:0] hour;   // up to 45
    logic [2:0] wday;
    logic [5:0] date;   // up to 45
    logic [4:0] month;  // up to 25
    logic       leap;
    logic [4:0] keep;   // old alarm weekday bits 7..3
  } now_t;

  // Work item handed from the front to the back
  typedef struct packed {
    logic       slot;
    now_t       now;
    logic       dday;
    logic [4:0] d_hour;
    logic [5:0] d_min;
    logic [5:0] d_sec;
  } job_t;

  // Days in a month; month already known to lie in 1..12
  function automatic logic [5:0] month_len(input logic [4:0] month, input logic leap);
    logic [5:0] len;
    case (month)
      5'd2:    len = leap ? 6'd29 : 6'd28;
      5'd4,
      5'd6,
      5'd9,
      5'd11:   len = 6'd30;
      default: len = 6'd31;
    endcase
    return len;
  endfunction

  // Binary to two-digit BCD for values below 64
  function automatic logic [6:0] to_bcd(input logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] units;
    if (v >= 6'd60) begin
      tens = 3'd6;
    end else if (v >= 6'd50) begin
      tens = 3'd5;
    end else if (v >= 6'd40) begin
      tens = 3'd4;
    end else if (v >= 6'd30) begin
      tens = 3'd3;
    end else if (v >= 6'd20) begin
      tens = 3'd2;
    end else if (v >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    units = v - 6'(tens) * 6'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

/* sv/raot_front.sv */
// ----------------------------------------------------------------------------
// raot_front
// Decodes the raw BCD clock registers and splits the delay into whole days,
// hours, minutes and seconds over a five-stage pipeline.
// ----------------------------------------------------------------------------
module raot_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_slot,
  input  logic [raot_pkg::IN_DATA_W-1:0] in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output raot_pkg::job_t                 out_job
);

  localparam int STAGES = 5;

  raot_pkg::job_t    job [STAGES];
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vld_next;
  logic [STAGES-1:0] adv;

  // per-stage side payload
  logic [16:0] rem0, rem1;
  logic [4:0]  qh1;
  logic [11:0] remh2, remh3;
  logic [5:0]  qm3;

  // stage 0 inputs
  raot_pkg::job_t in_job;
  logic [16:0]    delay;
  logic [16:0]    rem_in;

  // stage 1..4 combinational results
  logic [27:0]    prod_h;
  logic [16:0]    remh_w;
  logic [4:0]     hour_fix;
  logic [11:0]    remh_fix;
  logic [22:0]    prod_m;
  logic [11:0]    rm_w;
  logic [5:0]     min_fix;
  logic [5:0]     sec_fix;
  raot_pkg::job_t job2_n;
  raot_pkg::job_t job4_n;

  // handshake chain: a stage loads when it is empty or its successor loads
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[STAGES-1];
  assign out_job   = job[STAGES-1];

  // stage 0: BCD decode, day split
  always_comb begin
    delay           = in_data[16:0];
    in_job          = '0;
    in_job.slot     = in_slot;
    in_job.now.sec  = 7'(in_data[20:17]) + 7'(in_data[23:21]) * 7'd10;
    in_job.now.min  = 7'(in_data[28:25]) + 7'(in_data[31:29]) * 7'd10;
    in_job.now.hour = 6'(in_data[36:33]) + 6'(in_data[38:37]) * 6'd10;
    in_job.now.wday = in_data[43:41];
    in_job.now.date = 6'(in_data[52:49]) + 6'(in_data[54:53]) * 6'd10;
    in_job.now.month = 5'(in_data[60:57]) + (in_data[61] ? 5'd10 : 5'd0);
    in_job.now.leap = in_data[62];
    in_job.now.keep = in_data[72:68];
    in_job.dday     = (delay >= raot_pkg::SEC_PER_DAY);
    rem_in          = in_job.dday ? delay - raot_pkg::SEC_PER_DAY : delay;
  end

  // stage 1: hour estimate
  assign prod_h = 28'(rem0) * 28'(raot_pkg::HOUR_RECIP);

  // stage 2: hour correction
  always_comb begin
    remh_w = rem1 - 17'(qh1) * 17'(raot_pkg::SEC_PER_HOUR);
    if (remh_w >= 17'(raot_pkg::SEC_PER_HOUR)) begin
      hour_fix = qh1 + 5'd1;
      remh_fix = 12'(remh_w - 17'(raot_pkg::SEC_PER_HOUR));
    end else begin
      hour_fix = qh1;
      remh_fix = 12'(remh_w);
    end
    job2_n        = job[1];
    job2_n.d_hour = hour_fix;
  end

  // stage 3: minute estimate
  assign prod_m = 23'(remh2) * 23'(raot_pkg::MIN_RECIP);

  // stage 4: minute correction
  always_comb begin
    rm_w = remh3 - 12'(qm3) * 12'(raot_pkg::SEC_PER_MIN);
    if (rm_w >= 12'(raot_pkg::SEC_PER_MIN)) begin
      min_fix = qm3 + 6'd1;
      sec_fix = 6'(rm_w - 12'(raot_pkg::SEC_PER_MIN));
    end else begin
      min_fix = qm3;
      sec_fix = 6'(rm_w);
    end
    job4_n       = job[3];
    job4_n.d_min = min_fix;
    job4_n.d_sec = sec_fix;
  end

  // next valid bits
  always_comb begin
    vld_next = vld;
    if (adv[0]) begin
      vld_next[0] = in_valid;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (adv[i]) begin
        vld_next[i] = vld[i-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      job[0] <= in_job;
      rem0   <= rem_in;
    end
    if (adv[1]) begin
      job[1] <= job[0];
      rem1   <= rem0;
      qh1    <= prod_h[raot_pkg::HOUR_SHIFT +: 5];
    end
    if (adv[2]) begin
      job[2] <= job2_n;
      remh2  <= remh_fix;
    end
    if (adv[3]) begin
      job[3] <= job[2];
      remh3  <= remh2;
      qm3    <= prod_m[raot_pkg::MIN_SHIFT +: 6];
    end
    if (adv[4]) begin
      job[4] <= job4_n;
    end
  end

endmodule

/* sv/raot_fifo.sv */
// ----------------------------------------------------------------------------
// raot_fifo
// Short queue of work items between the front and the back.
// ----------------------------------------------------------------------------
module raot_fifo #(
  parameter int DEPTH = raot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  raot_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output raot_pkg::job_t out_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  raot_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_job   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/raot_back.sv */
// ----------------------------------------------------------------------------
// raot_back
// Adds the split delay to the decoded time with carries through seconds,
// minutes, hours, weekday, day of month and month, then encodes in BCD.
// ----------------------------------------------------------------------------
module raot_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  raot_pkg::job_t                  in_job,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [raot_pkg::OUT_DATA_W-1:0] out_data,
  output logic [raot_pkg::OUT_USER_W-1:0] out_user
);

  // stage 1 register
  logic           v1;
  logic           slot1;
  raot_pkg::now_t now1;
  logic           dday1;
  logic           c_hour1;
  logic [5:0]     sec1, min1;
  logic [4:0]     hour1;

  logic           adv1, adv_o;
  logic           out_vld;

  // stage 1 combinational
  logic [7:0] s_sum, m_sum;
  logic [6:0] h_sum;
  logic       c_sec, c_min, c_hour;
  logic [5:0] sec_n, min_n;
  logic [4:0] hour_n;

  // stage 2 combinational
  logic [1:0] inc;
  logic [3:0] w_sum, w_m1;
  logic [2:0] wday_n;
  logic       bad;
  logic [5:0] mlen;
  logic [5:0] d_sum, date_n;
  logic       c_date;
  logic [4:0] mo_sum, mo_m1;
  logic [3:0] month_n;
  logic [7:0] wday_byte;
  logic [6:0] sec_bcd, min_bcd, hour_bcd, date_bcd, month_bcd;
  logic [raot_pkg::OUT_DATA_W-1:0] data_n;

  assign adv_o     = !out_vld || out_ready;
  assign adv1      = !v1 || adv_o;
  assign in_ready  = adv1;
  assign out_valid = out_vld;

  // seconds, minutes, hours with carries
  always_comb begin
    s_sum = 8'(in_job.now.sec) + 8'(in_job.d_sec);
    c_sec = (s_sum >= 8'd60);
    if (s_sum >= 8'd120) begin
      sec_n = 6'(s_sum - 8'd120);
    end else if (c_sec) begin
      sec_n = 6'(s_sum - 8'd60);
    end else begin
      sec_n = 6'(s_sum);
    end

    m_sum = 8'(in_job.now.min) + 8'(in_job.d_min) + 8'(c_sec);
    c_min = (m_sum >= 8'd60);
    if (m_sum >= 8'd120) begin
      min_n = 6'(m_sum - 8'd120);
    end else if (c_min) begin
      min_n = 6'(m_sum - 8'd60);
    end else begin
      min_n = 6'(m_sum);
    end

    h_sum  = 7'(in_job.now.hour) + 7'(in_job.d_hour) + 7'(c_min);
    c_hour = (h_sum >= 7'd24);
    if (h_sum >= 7'd48) begin
      hour_n = 5'(h_sum - 7'd48);
    end else if (c_hour) begin
      hour_n = 5'(h_sum - 7'd24);
    end else begin
      hour_n = 5'(h_sum);
    end
  end

  // weekday, date, month, then BCD encode
  always_comb begin
    inc   = 2'(dday1) + 2'(c_hour1);

    w_sum = 4'(now1.wday) + 4'(inc);
    w_m1  = w_sum - 4'd1;
    if (w_sum == 4'd0) begin
      wday_n = 3'd0;
    end else if (w_m1 >= 4'd7) begin
      wday_n = 3'(w_m1 - 4'd6);
    end else begin
      wday_n = 3'(w_m1 + 4'd1);
    end

    bad  = (now1.month == 5'd0) || (now1.month > 5'd12);
    mlen = bad ? 6'd31 : raot_pkg::month_len(now1.month, now1.leap);

    d_sum  = now1.date + 6'(inc);
    c_date = (d_sum > mlen);
    date_n = c_date ? d_sum - (mlen + 6'd1) : d_sum;
    if (date_n == 6'd0) begin
      date_n = 6'd1;
    end

    mo_sum = now1.month + 5'(c_date);
    mo_m1  = mo_sum - 5'd1;
    if (mo_sum == 5'd0) begin
      month_n = 4'd0;
    end else if (mo_m1 >= 5'd24) begin
      month_n = 4'(mo_m1 - 5'd23);
    end else if (mo_m1 >= 5'd12) begin
      month_n = 4'(mo_m1 - 5'd11);
    end else begin
      month_n = 4'(mo_m1 + 5'd1);
    end

    wday_byte = ({now1.keep, 3'b000} & raot_pkg::KEEP_WDAY_MASK)
              | raot_pkg::FULL_MATCH_MASK | {5'b00000, wday_n};

    sec_bcd   = raot_pkg::to_bcd(sec1);
    min_bcd   = raot_pkg::to_bcd(min1);
    hour_bcd  = raot_pkg::to_bcd(6'(hour1));
    date_bcd  = raot_pkg::to_bcd(date_n);
    month_bcd = raot_pkg::to_bcd(6'(month_n));

    data_n = {1'b0,
              month_bcd[4:0],
              date_bcd[5:0],
              wday_byte,
              hour_bcd[5:0],
              min_bcd,
              sec_bcd};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv_o) begin
        out_vld <= v1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv1) begin
      slot1   <= in_job.slot;
      now1    <= in_job.now;
      dday1   <= in_job.dday;
      c_hour1 <= c_hour;
      sec1    <= sec_n;
      min1    <= min_n;
      hour1   <= hour_n;
    end
    if (adv_o) begin
      out_data <= data_n;
      out_user <= {bad, slot1};
    end
  end

endmodule

/* sv/rtc_alarm_time_offset.sv */
// ----------------------------------------------------------------------------
// rtc_alarm_time_offset
// Computes RTC alarm registers from the current BCD time plus a delay.
// ----------------------------------------------------------------------------
// Path: an input transfer loads front stage 0, then passes through 4 more
//   front stages, the queue and 2 back stages; a stalled output holds it.
// Throughput: one item per cycle unless stalled; every stage fully pipelined.
// Reset: synchronous rst clears all valid bits and the queue; no clearing pass.
module rtc_alarm_time_offset #(
  parameter int QUEUE_DEPTH = raot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [16:0] delay_seconds, [24:17] sec_reg, [32:25] min_reg, [40:33] hour_reg,
  // [48:41] weekday_reg, [56:49] date_reg, [64:57] month_reg,
  // [72:65] old_alarm_wday_reg, [79:73] zero
  input  logic [raot_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] which_alarm
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [6:0] alarm_sec_bcd, [13:7] alarm_min_bcd, [19:14] alarm_hour_bcd,
  // [27:20] alarm_wday_byte, [33:28] alarm_date_bcd, [38:34] alarm_month_bcd,
  // [39] zero
  output logic [raot_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] alarm_slot, [1] bad_month
  output logic [raot_pkg::OUT_USER_W-1:0] m_tuser
);

  logic           fe_valid, fe_ready;
  raot_pkg::job_t fe_job;
  logic           be_valid, be_ready;
  raot_pkg::job_t be_job;

  raot_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_slot   (s_tuser),
    .in_data   (s_tdata),
    .out_valid (fe_valid),
    .out_ready (fe_ready),
    .out_job   (fe_job)
  );

  raot_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_job    (fe_job),
    .out_valid (be_valid),
    .out_ready (be_ready),
    .out_job   (be_job)
  );

  raot_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (be_valid),
    .in_ready  (be_ready),
    .in_job    (be_job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule
